FILE: src/quadratic_root_solver_defines.svh
// ----------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Shared concurrent assertion wrappers, clocked on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// same-cycle implication
`define QRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qrs assertion failed");

// next-cycle implication
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qrs assertion failed");

`endif

FILE: src/qrs_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Root class codes and the field width shared by the solver files.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int FIELD_BITS = 32;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TWO  = 2'd1,
    KIND_ONE  = 2'd2,
    KIND_CPX  = 2'd3
  } root_kind_t;

endpackage

FILE: src/qrs_in_if.sv
// ----------------------------------------------------------------------------
// Coefficient channel
// valid/ready channel carrying one set of Q16.16 coefficients.
// ----------------------------------------------------------------------------
interface qrs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [qrs_pkg::FIELD_BITS-1:0] coef_a;
  logic signed [qrs_pkg::FIELD_BITS-1:0] coef_b;
  logic signed [qrs_pkg::FIELD_BITS-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

FILE: src/qrs_out_if.sv
// ----------------------------------------------------------------------------
// Root channel
// valid/ready channel carrying the root class, two values and overflow.
// ----------------------------------------------------------------------------
interface qrs_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            root_kind;
  logic signed [qrs_pkg::FIELD_BITS-1:0] first_value;
  logic signed [qrs_pkg::FIELD_BITS-1:0] second_value;
  logic                                  overflow;

  modport source (output valid, root_kind, first_value, second_value, overflow,
                  input ready);
  modport sink   (input valid, root_kind, first_value, second_value, overflow,
                  output ready);
endinterface

FILE: src/qrs_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one root bit resolved per register stage.
// ----------------------------------------------------------------------------
module qrs_sqrt_pipe #(
  parameter int IN_BITS = 66
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [IN_BITS-1:0]   radicand,
  output logic [IN_BITS/2-1:0] root
);

  localparam int RB = IN_BITS / 2;
  localparam int RW = RB + 2;

  logic [IN_BITS-1:0] rad_q  [RB];
  logic [RW-1:0]      rem_q  [RB];
  logic [RB-1:0]      root_q [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [IN_BITS-1:0] rad_in;
    logic [RW-1:0]      rem_in;
    logic [RB-1:0]      root_in;
    logic [RW+1:0]      cat;
    logic [RW+1:0]      trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign rad_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down two radicand bits, try (root*4 + 1)
    assign cat   = {rem_in, rad_in[IN_BITS-1 -: 2]};
    assign trial = (RW+2)'({root_in, 2'b01});
    assign ge    = cat >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? RW'(cat - trial) : RW'(cat);
        root_q[k] <= RB'({root_in, ge});
      end
    end
  end

  assign root = root_q[RB-1];

endmodule

FILE: src/qrs_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, floor result.
// ----------------------------------------------------------------------------
module qrs_div_pipe #(
  parameter int NUM_BITS = 50,
  parameter int DEN_BITS = 33
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NUM_BITS-1:0] numer,
  input  logic [DEN_BITS-1:0] denom,
  output logic [NUM_BITS-1:0] quot
);

  logic [NUM_BITS-1:0] num_q [NUM_BITS];
  logic [DEN_BITS-1:0] den_q [NUM_BITS];
  logic [DEN_BITS-1:0] rem_q [NUM_BITS];
  logic [NUM_BITS-1:0] quo_q [NUM_BITS];

  for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
    logic [NUM_BITS-1:0] num_in;
    logic [DEN_BITS-1:0] den_in;
    logic [DEN_BITS-1:0] rem_in;
    logic [NUM_BITS-1:0] quo_in;
    logic [DEN_BITS:0]   cat;
    logic                ge;

    if (k == 0) begin : g_first
      assign num_in = numer;
      assign den_in = denom;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign cat = {rem_in, num_in[NUM_BITS-1]};
    assign ge  = cat >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        num_q[k] <= num_in << 1;
        den_q[k] <= den_in;
        rem_q[k] <= ge ? DEN_BITS'(cat - {1'b0, den_in}) : DEN_BITS'(cat);
        quo_q[k] <= {quo_in[NUM_BITS-2:0], ge};
      end
    end
  end

  assign quot = quo_q[NUM_BITS-1];

endmodule

FILE: src/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// Quadratic root solver
// Roots of a*x^2 + b*x + c = 0 for signed fixed-point coefficients.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  coef    | in  | coef_a, coef_b, coef_c
//  roots   | out | root_kind, first_value, second_value, overflow
//
//  One request enters per cycle while the output is not stalled. The pipeline
//  has 3 front stages, WORD_BITS+1 square root stages, one numerator stage,
//  WORD_BITS+FRAC_BITS+2 divider stages and one output stage.
//  Reset clears only the stage valid bits. While a result sits unread the
//  whole pipeline holds; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  qrs_in_if.sink    coef,
  qrs_out_if.source roots
);

  localparam int W    = WORD_BITS;
  localparam int PW   = 2 * W;
  localparam int DW   = 2 * W + 2;
  localparam int RB   = DW / 2;
  localparam int NW   = W + 2;
  localparam int QW   = NW + FRAC_BITS;
  localparam int DENW = W + 1;
  localparam int FB   = qrs_pkg::FIELD_BITS;

  typedef struct packed {
    logic                vld;
    logic                az;
    qrs_pkg::root_kind_t kind;
    logic                sa;
    logic                sb;
    logic [W-1:0]        ma;
    logic [W-1:0]        mb;
  } sq_side_t;

  typedef struct packed {
    logic                vld;
    logic                az;
    qrs_pkg::root_kind_t kind;
    logic                neg_a;
    logic                neg_b;
  } dv_side_t;

  function automatic logic [NW:0] sm_add(input logic sx, input logic [NW-1:0] x,
                                         input logic sy, input logic [NW-1:0] y);
    logic [NW:0] r;
    if (sx == sy) r = {sx, x + y};
    else if (x >= y) r = {sx, x - y};
    else r = {sy, y - x};
    return r;
  endfunction

  function automatic logic [W:0] sat_word(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] lim;
    logic [W-1:0]  mag;
    logic          ovf;
    lim = (QW'(1) << (W - 1)) - (neg ? QW'(0) : QW'(1));
    ovf = q > lim;
    mag = ovf ? W'(lim) : W'(q);
    return {ovf, neg ? W'(~mag + W'(1)) : mag};
  endfunction

  logic en;
  assign en         = !roots.valid || roots.ready;
  assign coef.ready = en;

  // stage 1: magnitudes
  logic [W-1:0] a_w, b_w, c_w;
  assign a_w = W'(coef.coef_a);
  assign b_w = W'(coef.coef_b);
  assign c_w = W'(coef.coef_c);

  logic         s1_vld, s1_sa, s1_sb, s1_sc;
  logic [W-1:0] s1_ma, s1_mb, s1_mc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= coef.valid;
    end
    if (en) begin
      s1_sa <= a_w[W-1];
      s1_sb <= b_w[W-1];
      s1_sc <= c_w[W-1];
      s1_ma <= a_w[W-1] ? W'(~a_w + W'(1)) : a_w;
      s1_mb <= b_w[W-1] ? W'(~b_w + W'(1)) : b_w;
      s1_mc <= c_w[W-1] ? W'(~c_w + W'(1)) : c_w;
    end
  end

  // stage 2: products
  logic          s2_vld, s2_sa, s2_sb, s2_sp, s2_az;
  logic [PW-1:0] s2_b2, s2_ac;
  logic [W-1:0]  s2_ma, s2_mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
    if (en) begin
      s2_b2 <= s1_mb * s1_mb;
      s2_ac <= s1_ma * s1_mc;
      s2_sa <= s1_sa;
      s2_sb <= s1_sb;
      s2_sp <= s1_sa == s1_sc;
      s2_az <= s1_ma == '0;
      s2_ma <= s1_ma;
      s2_mb <= s1_mb;
    end
  end

  // stage 3: discriminant b*b - 4ac, sign-magnitude
  logic [DW-1:0] p4, b2e, dmag;
  logic          dneg;
  qrs_pkg::root_kind_t kind3;

  assign p4  = {s2_ac, 2'b00};
  assign b2e = DW'(s2_b2);

  always_comb begin
    if (!s2_sp) begin
      dmag = b2e + p4;
      dneg = 1'b0;
    end else if (b2e >= p4) begin
      dmag = b2e - p4;
      dneg = 1'b0;
    end else begin
      dmag = p4 - b2e;
      dneg = 1'b1;
    end
    if (dmag == '0)  kind3 = qrs_pkg::KIND_ONE;
    else if (dneg)   kind3 = qrs_pkg::KIND_CPX;
    else             kind3 = qrs_pkg::KIND_TWO;
  end

  logic          s3_vld;
  sq_side_t      s3_side;
  logic [DW-1:0] s3_dmag;

  assign s3_vld = s3_side.vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_side.vld <= 1'b0;
    end else if (en) begin
      s3_side.vld <= s2_vld;
    end
    if (en) begin
      s3_dmag      <= dmag;
      s3_side.az   <= s2_az;
      s3_side.kind <= kind3;
      s3_side.sa   <= s2_sa;
      s3_side.sb   <= s2_sb;
      s3_side.ma   <= s2_ma;
      s3_side.mb   <= s2_mb;
    end
  end

  // square root with matching sideband delay
  logic [RB-1:0] root;
  sq_side_t      sq_side [RB];

  qrs_sqrt_pipe #(.IN_BITS(DW)) u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s3_dmag),
    .root     (root)
  );

  for (genvar k = 0; k < RB; k++) begin : g_sq_side
    sq_side_t side_in;
    if (k == 0) begin : g_first
      always_comb begin
        side_in     = s3_side;
        side_in.vld = s3_vld;
      end
    end else begin : g_next
      assign side_in = sq_side[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_side[k].vld <= 1'b0;
      end else if (en) begin
        sq_side[k].vld <= side_in.vld;
      end
      if (en) begin
        sq_side[k].az   <= side_in.az;
        sq_side[k].kind <= side_in.kind;
        sq_side[k].sa   <= side_in.sa;
        sq_side[k].sb   <= side_in.sb;
        sq_side[k].ma   <= side_in.ma;
        sq_side[k].mb   <= side_in.mb;
      end
    end
  end

  // stage 4: numerators for both dividers
  sq_side_t      sqo;
  logic [NW-1:0] nb, se;
  logic [NW:0]   n1, n2;
  logic [NW-1:0] num_a, num_b;
  logic          sn_a, sn_b;

  assign sqo = sq_side[RB-1];
  assign nb  = NW'(sqo.mb);
  assign se  = NW'(root);
  assign n1  = sm_add(!sqo.sb, nb, 1'b0, se);
  assign n2  = sm_add(!sqo.sb, nb, 1'b1, se);

  always_comb begin
    num_a = nb;
    sn_a  = !sqo.sb;
    num_b = nb;
    sn_b  = !sqo.sb;
    case (sqo.kind)
      qrs_pkg::KIND_TWO: begin
        num_a = n1[NW-1:0];
        sn_a  = n1[NW];
        num_b = n2[NW-1:0];
        sn_b  = n2[NW];
      end
      qrs_pkg::KIND_CPX: begin
        num_b = se;
        sn_b  = 1'b0;
      end
      default: ;
    endcase
  end

  logic            s4_vld;
  dv_side_t        s4_side;
  logic [QW-1:0]   s4_num_a, s4_num_b;
  logic [DENW-1:0] s4_den;

  assign s4_vld = s4_side.vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_side.vld <= 1'b0;
    end else if (en) begin
      s4_side.vld <= sqo.vld;
    end
    if (en) begin
      s4_num_a      <= QW'(num_a) << FRAC_BITS;
      s4_num_b      <= QW'(num_b) << FRAC_BITS;
      s4_den        <= {sqo.ma, 1'b0};
      s4_side.az    <= sqo.az;
      s4_side.kind  <= sqo.kind;
      s4_side.neg_a <= sn_a != sqo.sa;
      s4_side.neg_b <= sn_b != sqo.sa;
    end
  end

  // dividers with matching sideband delay
  logic [QW-1:0] q_a, q_b;
  dv_side_t      dv_side [QW];

  qrs_div_pipe #(.NUM_BITS(QW), .DEN_BITS(DENW)) u_div_a (
    .clk   (clk),
    .en    (en),
    .numer (s4_num_a),
    .denom (s4_den),
    .quot  (q_a)
  );

  qrs_div_pipe #(.NUM_BITS(QW), .DEN_BITS(DENW)) u_div_b (
    .clk   (clk),
    .en    (en),
    .numer (s4_num_b),
    .denom (s4_den),
    .quot  (q_b)
  );

  for (genvar k = 0; k < QW; k++) begin : g_dv_side
    dv_side_t side_in;
    if (k == 0) begin : g_first
      always_comb begin
        side_in     = s4_side;
        side_in.vld = s4_vld;
      end
    end else begin : g_next
      assign side_in = dv_side[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_side[k].vld <= 1'b0;
      end else if (en) begin
        dv_side[k].vld <= side_in.vld;
      end
      if (en) begin
        dv_side[k].az    <= side_in.az;
        dv_side[k].kind  <= side_in.kind;
        dv_side[k].neg_a <= side_in.neg_a;
        dv_side[k].neg_b <= side_in.neg_b;
      end
    end
  end

  // output stage: saturate and pack
  dv_side_t dvo;
  logic [W:0] res_a, res_b;

  assign dvo   = dv_side[QW-1];
  assign res_a = sat_word(q_a, dvo.neg_a);
  assign res_b = sat_word(q_b, dvo.neg_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      roots.valid <= 1'b0;
    end else if (en) begin
      roots.valid <= dvo.vld;
    end
    if (en) begin
      if (dvo.az) begin
        roots.root_kind    <= qrs_pkg::KIND_NONE;
        roots.first_value  <= '0;
        roots.second_value <= '0;
        roots.overflow     <= 1'b0;
      end else if (dvo.kind == qrs_pkg::KIND_ONE) begin
        roots.root_kind    <= dvo.kind;
        roots.first_value  <= FB'(res_a[W-1:0]);
        roots.second_value <= FB'(res_a[W-1:0]);
        roots.overflow     <= res_a[W];
      end else begin
        roots.root_kind    <= dvo.kind;
        roots.first_value  <= FB'(res_a[W-1:0]);
        roots.second_value <= FB'(res_b[W-1:0]);
        roots.overflow     <= res_a[W] | res_b[W];
      end
    end
  end

  `QRS_ASSERT_NOW(a_none_zero, roots.valid && roots.root_kind == qrs_pkg::KIND_NONE, roots.first_value == '0 && roots.second_value == '0 && !roots.overflow)
  `QRS_ASSERT_NOW(a_one_equal, roots.valid && roots.root_kind == qrs_pkg::KIND_ONE, roots.first_value == roots.second_value)
  `QRS_ASSERT_NEXT(a_hold_front, !en, $stable(s1_vld) && $stable(s3_vld) && $stable(s4_vld))
  `QRS_ASSERT_NEXT(a_accept_flow, coef.valid && en, s1_vld)

endmodule
